>>> hdl/qle_pkg.sv
// shared types, constants and field positions of the q-learning engine
`timescale 1ns / 1ps
`default_nettype none

package qle_pkg;

    localparam int STATE_COUNT  = 4096;
    localparam int ACTION_COUNT = 8;
    localparam int ROW_W        = $clog2(STATE_COUNT);
    localparam int COL_W        = $clog2(ACTION_COUNT);
    localparam int ADDR_W       = ROW_W + COL_W;
    localparam int DEPTH        = STATE_COUNT * ACTION_COUNT;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(ACTION_COUNT - 1);

    localparam int Q_W      = 24;
    localparam int REWARD_W = 16;
    localparam int DRAW_W   = 16;
    localparam int RATE_W   = 9;

    // shared multiplier: signed operand times unsigned q1.8 factor, rounded
    localparam int MAC_A_W    = 28;
    localparam int MAC_PROD_W = MAC_A_W + RATE_W + 1;
    localparam int MAC_RES_W  = MAC_PROD_W - 8;
    localparam int SUM_W      = MAC_RES_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(8388608);
    localparam logic signed [Q_W-1:0]   Q_MAX   = 24'sh7fffff;
    localparam logic signed [Q_W-1:0]   Q_MIN   = 24'sh800000;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THR = 2'd2;
    localparam logic [RATE_W-1:0] LEARN_RATE_RST  = 9'd128;
    localparam logic [RATE_W-1:0] DISCOUNT_RST    = 9'd230;
    localparam logic [DRAW_W-1:0] EXPLORE_THR_RST = 16'd13107;

    // input word layout
    localparam int IN_DATA_W = 88;
    localparam int IN_ROW_LO    = 0;
    localparam int IN_ACT_LO    = 12;
    localparam int IN_REWARD_LO = 15;
    localparam int IN_NROW_LO   = 31;
    localparam int IN_ENTRY_LO  = 43;
    localparam int IN_DRAW_LO   = 67;
    localparam int IN_RACT_LO   = 83;
    localparam int IN_USED_W    = 86;

    // output word layout
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USED_W = 53;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_CHOOSE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_PEEK,
        S_PEEK_WAIT,
        S_SCAN,
        S_SCAN_END,
        S_READQ,
        S_WAITQ,
        S_TSUM,
        S_SCALE,
        S_SUM,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [Q_W-1:0]    wdata;
    } t_mem_req;

    typedef struct packed {
        logic                      en;
        logic signed [MAC_A_W-1:0] a;
        logic [RATE_W-1:0]         b;
    } t_mac_req;

endpackage

`default_nettype wire

>>> hdl/tabular_q_learning_engine_core.sv
// top level of the q-learning engine: configuration registers and instances
// a new input word is taken only once the previous one has left its result
// word in the output register; the eight-entry row scan through the single
// table port and the two passes through the shared multiplier make greedy
// choose and update the longest operations
// reset clears the sequencer and output valid and restores the configuration;
// the table itself is not cleared
`timescale 1ns / 1ps
`default_nettype none

module tabular_q_learning_engine_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // row, action, reward, next row, entry value,
    // random draw, random action, zero pad
    input  wire [qle_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation
    input  wire [1:0]                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // chosen_action, chosen_value, explored, new_value, saturated, zero pad
    output logic [qle_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire                                i_cfg_we,
    input  wire [qle_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [qle_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [qle_pkg::RATE_W-1:0]  r_learn_rate;
    logic [qle_pkg::RATE_W-1:0]  r_discount;
    logic [qle_pkg::DRAW_W-1:0]  r_explore_threshold;

    qle_pkg::t_mem_req                          w_mem_req;
    logic [qle_pkg::Q_W-1:0]                    w_mem_rdata;
    qle_pkg::t_mac_req                          w_mac_req;
    logic signed [qle_pkg::MAC_RES_W-1:0]       w_mac_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate        <= qle_pkg::LEARN_RATE_RST;
            r_discount          <= qle_pkg::DISCOUNT_RST;
            r_explore_threshold <= qle_pkg::EXPLORE_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qle_pkg::CFG_LEARN_RATE:  r_learn_rate <= i_cfg_data[qle_pkg::RATE_W-1:0];
                qle_pkg::CFG_DISCOUNT:    r_discount   <= i_cfg_data[qle_pkg::RATE_W-1:0];
                qle_pkg::CFG_EXPLORE_THR: r_explore_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qle_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .i_learn_rate        (r_learn_rate),
        .i_discount          (r_discount),
        .i_explore_threshold (r_explore_threshold),
        .o_mem_req           (w_mem_req),
        .i_mem_rdata         (w_mem_rdata),
        .o_mac_req           (w_mac_req),
        .i_mac_res           (w_mac_res)
    );

    qle_qmem u_qmem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    qle_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_res (w_mac_res)
    );

endmodule

`default_nettype wire

>>> hdl/qle_qmem.sv
// q-value table, single port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module qle_qmem (
    input  wire                       i_clk,
    input  wire qle_pkg::t_mem_req    i_req,
    output logic [qle_pkg::Q_W-1:0]   o_rdata
);

    logic [qle_pkg::Q_W-1:0] r_mem [0:qle_pkg::DEPTH-1];
    logic [qle_pkg::Q_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/qle_mac.sv
// shared multiplier with round-half-up q1.8 scaling and result register
`timescale 1ns / 1ps
`default_nettype none

module qle_mac (
    input  wire                                       i_clk,
    input  wire qle_pkg::t_mac_req                    i_req,
    output logic signed [qle_pkg::MAC_RES_W-1:0]      o_res
);

    logic signed [qle_pkg::MAC_PROD_W-1:0] w_prod;
    logic signed [qle_pkg::MAC_PROD_W-1:0] w_round;
    logic signed [qle_pkg::MAC_RES_W-1:0]  r_res;

    always_comb begin
        w_prod  = $signed(i_req.a) * $signed({1'b0, i_req.b});
        w_round = (w_prod + qle_pkg::MAC_PROD_W'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_res <= w_round[qle_pkg::MAC_RES_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> hdl/qle_seq.sv
// operation sequencer: row scan, argmax, update arithmetic and output register
`timescale 1ns / 1ps
`default_nettype none

module qle_seq (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire [qle_pkg::IN_DATA_W-1:0]             s_axis_tdata,
    input  wire [1:0]                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    output logic [qle_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    input  wire [qle_pkg::RATE_W-1:0]                i_learn_rate,
    input  wire [qle_pkg::RATE_W-1:0]                i_discount,
    input  wire [qle_pkg::DRAW_W-1:0]                i_explore_threshold,
    output qle_pkg::t_mem_req                        o_mem_req,
    input  wire [qle_pkg::Q_W-1:0]                   i_mem_rdata,
    output qle_pkg::t_mac_req                        o_mac_req,
    input  wire signed [qle_pkg::MAC_RES_W-1:0]      i_mac_res
);

    qle_pkg::t_state r_state, n_state;

    qle_pkg::t_op                       r_op;
    logic [qle_pkg::ROW_W-1:0]          r_row;
    logic [qle_pkg::ROW_W-1:0]          r_scan_row;
    logic [qle_pkg::COL_W-1:0]          r_col;
    logic [qle_pkg::COL_W-1:0]          r_ract;
    logic signed [qle_pkg::REWARD_W-1:0] r_reward;
    logic [qle_pkg::Q_W-1:0]            r_entry;
    logic                               r_explore;

    logic [qle_pkg::COL_W-1:0]          r_scan_col;
    logic                               r_cmp_vld;
    logic [qle_pkg::COL_W-1:0]          r_cmp_col;
    logic signed [qle_pkg::Q_W-1:0]     r_best;
    logic [qle_pkg::COL_W-1:0]          r_best_idx;

    logic signed [qle_pkg::Q_W-1:0]     r_q;
    logic signed [qle_pkg::MAC_A_W-1:0] r_tq;
    logic signed [qle_pkg::Q_W-1:0]     r_new;
    logic                               r_sat;

    logic                               r_out_vld;
    logic [qle_pkg::OUT_DATA_W-1:0]     r_out_data;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_load_out;
    logic                               w_explore_in;
    qle_pkg::t_op                       w_op_in;
    logic signed [qle_pkg::MAC_A_W-1:0] w_t;
    logic signed [qle_pkg::SUM_W-1:0]   w_sum;
    logic signed [qle_pkg::Q_W-1:0]     w_new;
    logic                               w_sat;
    logic [qle_pkg::OUT_DATA_W-1:0]     w_out_data;

    assign w_op_in      = qle_pkg::t_op'(s_axis_tuser);
    assign w_explore_in = s_axis_tdata[qle_pkg::IN_DRAW_LO +: qle_pkg::DRAW_W]
                          < i_explore_threshold;
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_out_free   = !r_out_vld || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qle_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (w_op_in)
                        qle_pkg::OP_WRITE:  n_state = qle_pkg::S_WRITE;
                        qle_pkg::OP_CHOOSE: n_state = w_explore_in ? qle_pkg::S_PEEK
                                                                   : qle_pkg::S_SCAN;
                        qle_pkg::OP_UPDATE: n_state = qle_pkg::S_SCAN;
                        default:            n_state = qle_pkg::S_FINISH;
                    endcase
                end
            end
            qle_pkg::S_WRITE:     n_state = qle_pkg::S_FINISH;
            qle_pkg::S_PEEK:      n_state = qle_pkg::S_PEEK_WAIT;
            qle_pkg::S_PEEK_WAIT: n_state = qle_pkg::S_FINISH;
            qle_pkg::S_SCAN: begin
                if (r_scan_col == qle_pkg::COL_LAST) begin
                    n_state = qle_pkg::S_SCAN_END;
                end
            end
            qle_pkg::S_SCAN_END: begin
                n_state = (r_op == qle_pkg::OP_UPDATE) ? qle_pkg::S_READQ
                                                       : qle_pkg::S_FINISH;
            end
            qle_pkg::S_READQ: n_state = qle_pkg::S_WAITQ;
            qle_pkg::S_WAITQ: n_state = qle_pkg::S_TSUM;
            qle_pkg::S_TSUM:  n_state = qle_pkg::S_SCALE;
            qle_pkg::S_SCALE: n_state = qle_pkg::S_SUM;
            qle_pkg::S_SUM:   n_state = qle_pkg::S_FINISH;
            qle_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = qle_pkg::S_IDLE;
                end
            end
            default: n_state = qle_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        o_mem_req     = '0;
        o_mac_req     = '0;
        case (r_state)
            qle_pkg::S_IDLE: s_axis_tready = 1'b1;
            qle_pkg::S_WRITE: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = {r_row, r_col};
                o_mem_req.wdata = r_entry;
            end
            qle_pkg::S_PEEK: begin
                o_mem_req.re   = 1'b1;
                o_mem_req.addr = {r_row, r_ract};
            end
            qle_pkg::S_SCAN: begin
                o_mem_req.re   = 1'b1;
                o_mem_req.addr = {r_scan_row, r_scan_col};
            end
            qle_pkg::S_READQ: begin
                o_mem_req.re   = 1'b1;
                o_mem_req.addr = {r_row, r_col};
            end
            qle_pkg::S_WAITQ: begin
                o_mac_req.en = 1'b1;
                o_mac_req.a  = qle_pkg::MAC_A_W'(r_best);
                o_mac_req.b  = i_discount;
            end
            qle_pkg::S_SCALE: begin
                o_mac_req.en = 1'b1;
                o_mac_req.a  = r_tq;
                o_mac_req.b  = i_learn_rate;
            end
            qle_pkg::S_SUM: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = {r_row, r_col};
                o_mem_req.wdata = w_new;
            end
            qle_pkg::S_FINISH: w_load_out = w_out_free;
            default: ;
        endcase
    end

    // update arithmetic around the shared multiplier
    always_comb begin
        w_t   = qle_pkg::MAC_A_W'($signed({r_reward, 8'd0}))
              + $signed(i_mac_res[qle_pkg::MAC_A_W-1:0]);
        w_sum = qle_pkg::SUM_W'(r_q) + qle_pkg::SUM_W'(i_mac_res);
        w_sat = 1'b0;
        w_new = w_sum[qle_pkg::Q_W-1:0];
        if (w_sum > qle_pkg::SUM_MAX) begin
            w_new = qle_pkg::Q_MAX;
            w_sat = 1'b1;
        end else if (w_sum < qle_pkg::SUM_MIN) begin
            w_new = qle_pkg::Q_MIN;
            w_sat = 1'b1;
        end
    end

    // result word
    always_comb begin
        w_out_data = '0;
        case (r_op)
            qle_pkg::OP_WRITE: w_out_data[51:28] = r_entry;
            qle_pkg::OP_CHOOSE: begin
                w_out_data[2:0]  = r_best_idx;
                w_out_data[26:3] = r_best;
                w_out_data[27]   = r_explore;
            end
            qle_pkg::OP_UPDATE: begin
                w_out_data[51:28] = r_new;
                w_out_data[52]    = r_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= qle_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == qle_pkg::S_SCAN);
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= w_op_in;
            r_row      <= s_axis_tdata[qle_pkg::IN_ROW_LO +: qle_pkg::ROW_W];
            r_col      <= s_axis_tdata[qle_pkg::IN_ACT_LO +: qle_pkg::COL_W];
            r_reward   <= s_axis_tdata[qle_pkg::IN_REWARD_LO +: qle_pkg::REWARD_W];
            r_entry    <= s_axis_tdata[qle_pkg::IN_ENTRY_LO +: qle_pkg::Q_W];
            r_ract     <= s_axis_tdata[qle_pkg::IN_RACT_LO +: qle_pkg::COL_W];
            r_explore  <= w_explore_in;
            r_scan_row <= (w_op_in == qle_pkg::OP_UPDATE)
                        ? s_axis_tdata[qle_pkg::IN_NROW_LO +: qle_pkg::ROW_W]
                        : s_axis_tdata[qle_pkg::IN_ROW_LO +: qle_pkg::ROW_W];
            r_scan_col <= '0;
        end else if (r_state == qle_pkg::S_SCAN) begin
            r_scan_col <= r_scan_col + 1'b1;
        end
        r_cmp_col <= r_scan_col;

        // running maximum, ties keep the lower column
        if (r_cmp_vld) begin
            if (r_cmp_col == '0 || $signed(i_mem_rdata) > r_best) begin
                r_best     <= $signed(i_mem_rdata);
                r_best_idx <= r_cmp_col;
            end
        end else if (r_state == qle_pkg::S_PEEK_WAIT) begin
            r_best     <= $signed(i_mem_rdata);
            r_best_idx <= r_ract;
        end

        if (r_state == qle_pkg::S_WAITQ) begin
            r_q <= $signed(i_mem_rdata);
        end
        if (r_state == qle_pkg::S_TSUM) begin
            r_tq <= w_t - qle_pkg::MAC_A_W'(r_q);
        end
        if (r_state == qle_pkg::S_SUM) begin
            r_new <= w_new;
            r_sat <= w_sat;
        end
        if (w_load_out) begin
            r_out_data <= w_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench of the q-learning engine core: directed and random words on both streams
`timescale 1ns / 1ps

package qle_tb_pkg;
    import qle_pkg::*;

    // one input word without the operation, last field in the highest bits
    typedef struct packed {
        logic [COL_W-1:0]           ract;
        logic [DRAW_W-1:0]          draw;
        logic signed [Q_W-1:0]      entry;
        logic [ROW_W-1:0]           nrow;
        logic signed [REWARD_W-1:0] reward;
        logic [COL_W-1:0]           act;
        logic [ROW_W-1:0]           row;
    } t_fields;

    typedef struct packed {
        logic                  saturated;
        logic signed [Q_W-1:0] new_value;
        logic                  explored;
        logic signed [Q_W-1:0] chosen_value;
        logic [COL_W-1:0]      chosen_action;
    } t_result;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class q_table_scoreboard;
        logic signed [Q_W-1:0] q_mem [DEPTH];
        bit                    loaded [DEPTH];
        logic [RATE_W-1:0]     learn_rate;
        logic [RATE_W-1:0]     discount;
        logic [DRAW_W-1:0]     explore_thr;
        t_result               due_results [$];
        int                    errors;

        function new();
            learn_rate  = LEARN_RATE_RST;
            discount    = DISCOUNT_RST;
            explore_thr = EXPLORE_THR_RST;
            errors      = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function bit row_loaded(logic [ROW_W-1:0] row);
            for (int a = 0; a < ACTION_COUNT; a++) begin
                if (!loaded[{row, COL_W'(a)}]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LEARN_RATE:  learn_rate  = val[RATE_W-1:0];
                CFG_DISCOUNT:    discount    = val[RATE_W-1:0];
                CFG_EXPLORE_THR: explore_thr = val[DRAW_W-1:0];
                default: ;
            endcase
        endfunction

        // floor((x + 128) / 256)
        function longint round_q8(longint x);
            return (x + 128) >>> 8;
        endfunction

        function void best_in_row(input logic [ROW_W-1:0] row, output logic [COL_W-1:0] col,
                                  output longint val);
            longint v;
            col = '0;
            val = q_mem[{row, col}];
            for (int a = 1; a < ACTION_COUNT; a++) begin
                v = q_mem[{row, COL_W'(a)}];
                if (v > val) begin
                    val = v;
                    col = COL_W'(a);
                end
            end
        endfunction

        function void note_word(t_op op, t_fields f);
            t_result           r;
            logic [ADDR_W-1:0] at;
            logic [COL_W-1:0]  bc;
            longint            best, q, t, d, nv;
            r  = '0;
            at = {f.row, f.act};
            case (op)
                OP_WRITE: begin
                    q_mem[at]   = f.entry;
                    loaded[at]  = 1'b1;
                    r.new_value = f.entry;
                end
                OP_CHOOSE: begin
                    if (f.draw < explore_thr) begin
                        r.chosen_action = f.ract;
                        r.chosen_value  = q_mem[{f.row, f.ract}];
                        r.explored      = 1'b1;
                    end else begin
                        best_in_row(f.row, bc, best);
                        r.chosen_action = bc;
                        r.chosen_value  = Q_W'(best);
                    end
                end
                OP_UPDATE: begin
                    best_in_row(f.nrow, bc, best);
                    q  = q_mem[at];
                    t  = longint'(f.reward) * 256 + round_q8(longint'(discount) * best);
                    d  = round_q8(longint'(learn_rate) * (t - q));
                    nv = q + d;
                    if (nv > longint'(Q_MAX)) begin
                        nv          = Q_MAX;
                        r.saturated = 1'b1;
                    end else if (nv < longint'(Q_MIN)) begin
                        nv          = Q_MIN;
                        r.saturated = 1'b1;
                    end
                    q_mem[at]   = Q_W'(nv);
                    r.new_value = Q_W'(nv);
                end
                default: ;
            endcase
            due_results.push_back(r);
        endfunction

        task report(string field, longint want, longint got);
            if (errors < 100) $display("mismatch on %s: expected %0d, got %0d", field, want, got);
            errors++;
        endtask

        task check_word(logic [OUT_DATA_W-1:0] w);
            t_result got, want;
            got = w[OUT_USED_W-1:0];
            if (due_results.size() == 0) begin
                report("unexpected word", 0, 1);
                return;
            end
            want = due_results.pop_front();
            if (got.chosen_action !== want.chosen_action)
                report("chosen_action", want.chosen_action, got.chosen_action);
            if (got.chosen_value !== want.chosen_value)
                report("chosen_value", $signed(want.chosen_value), $signed(got.chosen_value));
            if (got.explored !== want.explored)
                report("explored", want.explored, got.explored);
            if (got.new_value !== want.new_value)
                report("new_value", $signed(want.new_value), $signed(got.new_value));
            if (got.saturated !== want.saturated)
                report("saturated", want.saturated, got.saturated);
        endtask
    endclass
endpackage

module tb_top;
    import qle_pkg::*;
    import qle_tb_pkg::*;

    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 240;
    localparam int          BUILT_ROWS   = 12;
    localparam int          QUIET_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    q_table_scoreboard      sb = new();
    int                     send_idle = 25;
    int                     recv_idle = 49;
    int unsigned            cycle_count = 0;
    logic [ROW_W-1:0]       ready_rows [$];

    logic signed [Q_W-1:0]  row_lo [ACTION_COUNT] = '{Q_MIN, 7, Q_MAX, -1, Q_MAX, 0, -3, 7};
    logic signed [Q_W-1:0]  row_hi [ACTION_COUNT] = '{-2, -9, -2, Q_MIN, -100, -3, -2, -50};
    int unsigned            lr_set   [PHASES] = '{256, 0, 1, 200, 128, 256};
    int unsigned            disc_set [PHASES] = '{256, 0, 255, 128, 230, 1};
    int unsigned            thr_set  [PHASES] = '{0, 65535, 32768, 1, 13107, 65534};

    tabular_q_learning_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each accepted word, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic t_fields noise();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[$bits(t_fields)-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] rand_q();
        case ($urandom_range(7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return Q_W'(int'($urandom_range(2000)) - 1000);
            4:       return Q_W'(int'($urandom_range(2)) - 1);
            default: return Q_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [REWARD_W-1:0] rand_reward();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return REWARD_W'(int'($urandom_range(40)) - 20);
            default: return REWARD_W'($urandom);
        endcase
    endfunction

    function automatic logic [DRAW_W-1:0] rand_draw();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return sb.explore_thr;
            3:       return sb.explore_thr - 1'b1;
            default: return DRAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pick_ready();
        return ready_rows[$urandom_range(ready_rows.size() - 1)];
    endfunction

    task automatic push_word(input t_op op, input t_fields f);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'(f);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(op, f);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input int unsigned lr, input int unsigned disc,
                                input int unsigned thr);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idx  = '{CFG_LEARN_RATE, CFG_DISCOUNT, CFG_EXPLORE_THR, CFG_SPARE};
        vals = '{CFG_DATA_W'(lr), CFG_DATA_W'(disc), CFG_DATA_W'(thr), CFG_DATA_W'($urandom)};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.set_reg(idx[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_row(input logic [ROW_W-1:0] row, input logic signed [Q_W-1:0] v [ACTION_COUNT]);
        t_fields f;
        for (int c = 0; c < ACTION_COUNT; c++) begin
            f       = noise();
            f.row   = row;
            f.act   = COL_W'(c);
            f.entry = v[c];
            push_word(OP_WRITE, f);
        end
        ready_rows.push_back(row);
    endtask

    task automatic random_word();
        t_fields f;
        int      pick;
        f    = noise();
        pick = $urandom_range(99);
        if (pick < 20) begin
            if ($urandom_range(1)) f.row = pick_ready();
            f.entry = rand_q();
            push_word(OP_WRITE, f);
        end else if (pick < 55) begin
            f.row  = pick_ready();
            f.draw = rand_draw();
            push_word(OP_CHOOSE, f);
        end else if (pick < 95) begin
            f.row    = pick_ready();
            f.nrow   = pick_ready();
            f.reward = rand_reward();
            push_word(OP_UPDATE, f);
        end else begin
            push_word(OP_NONE, f);
        end
    endtask

    initial begin
        t_fields               f;
        logic signed [Q_W-1:0] vals [ACTION_COUNT];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings; ties, all-negative row, explore boundary, saturation both ways
        fill_row('0, row_lo);
        fill_row('1, row_hi);
        f = noise(); f.row = '0; f.draw = '1;
        push_word(OP_CHOOSE, f);
        f = noise(); f.row = '1; f.draw = EXPLORE_THR_RST;
        push_word(OP_CHOOSE, f);
        f = noise(); f.row = '0; f.draw = EXPLORE_THR_RST - 1'b1; f.ract = '1;
        push_word(OP_CHOOSE, f);
        f = noise(); f.row = '1; f.draw = '0; f.ract = 3'd3;
        push_word(OP_CHOOSE, f);
        f = noise(); f.row = '0; f.act = 3'd2; f.reward = 16'sh7fff; f.nrow = '0;
        push_word(OP_UPDATE, f);
        f = noise(); f.row = '1; f.act = 3'd3; f.reward = 16'sh8000; f.nrow = '1;
        push_word(OP_UPDATE, f);
        f = noise();
        push_word(OP_NONE, f);
        f = noise(); f.row = '0; f.act = '0; f.reward = '0; f.nrow = '1;
        push_word(OP_UPDATE, f);
        f = noise(); f.row = '1; f.act = '1; f.reward = 16'sd5; f.nrow = '0;
        push_word(OP_UPDATE, f);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            send_idle = (p < 2) ? 25 : (p < 4) ? 49 : 0;
            recv_idle = (p < 2) ? 49 : (p < 4) ? 25 : 0;
            program_regs(lr_set[p], disc_set[p], thr_set[p]);
            if (p == 0) begin
                for (int r = 0; r < BUILT_ROWS; r++) begin
                    foreach (vals[c]) vals[c] = rand_q();
                    fill_row(ROW_W'($urandom), vals);
                end
            end
            repeat (PHASE_ITEMS) random_word();
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/qle_pkg.sv
hdl/qle_qmem.sv
hdl/qle_mac.sv
hdl/qle_seq.sv
hdl/tabular_q_learning_engine_core.sv
tb/sv/tb_top.sv
